// ===== rtl/core/dual_queue_keyed_remove_macros.svh =====
// assertion helpers shared by the queue block
`ifndef DUAL_QUEUE_KEYED_REMOVE_MACROS_SVH
`define DUAL_QUEUE_KEYED_REMOVE_MACROS_SVH

// same-cycle implication
`define DQKR_ASSERT_NOW(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("dqkr assertion failed");

// next-cycle implication
`define DQKR_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("dqkr assertion failed");

`endif

// ===== rtl/core/dqkr_pkg.sv =====
// ----------------------------------------------------------------------------
// dqkr_pkg
// shared types and constants of the dual team queue
// ----------------------------------------------------------------------------
package dqkr_pkg;

    localparam int QUEUE_DEPTH_DEF    = 16;
    localparam int PLAYER_ID_BITS_DEF = 6;
    localparam int TICK_W             = 32;

    typedef enum logic [1:0] {
        MODE_ENQUEUE = 2'd0,
        MODE_REMOVE  = 2'd1,
        MODE_LOOKUP  = 2'd2,
        MODE_READ    = 2'd3
    } mode_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic scan_step;
        logic read_issue;
        logic decide;
        logic shift_step;
        logic read_capture;
        logic publish;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        mode_t mode;
        logic  found;
        logic  scan_done;
        logic  shift_done;
    } dp_status_t;

endpackage

// ===== rtl/core/dqkr_ram.sv =====
// ----------------------------------------------------------------------------
// dqkr_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module dqkr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/dqkr_ctrl.sv =====
// ----------------------------------------------------------------------------
// dqkr_ctrl
// sequencer for one request: scan, decide, shift or read, then publish
// ----------------------------------------------------------------------------
`include "dual_queue_keyed_remove_macros.svh"

module dqkr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dqkr_pkg::dp_cmd_t    cmd,
    input  dqkr_pkg::dp_status_t status
);

    import dqkr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_READ_WAIT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (status.mode == MODE_READ)
                begin
                    cmd.read_issue = 1'b1;
                    state_next     = S_READ_WAIT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (status.mode == MODE_REMOVE && status.found)
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (status.shift_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_READ_WAIT:
            begin
                cmd.read_capture = 1'b1;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `DQKR_ASSERT_NOW(a_shift_only_on_hit, clk, rst_n, state_reg == S_SHIFT, status.mode == MODE_REMOVE && status.found)
    `DQKR_ASSERT_NEXT(a_one_item_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

// ===== rtl/core/dqkr_datapath.sv =====
// ----------------------------------------------------------------------------
// dqkr_datapath
// request registers, queue counts, scan and shift pointers, result registers
// ----------------------------------------------------------------------------
`include "dual_queue_keyed_remove_macros.svh"

module dqkr_datapath #(
    parameter int QUEUE_DEPTH    = dqkr_pkg::QUEUE_DEPTH_DEF,
    parameter int PLAYER_ID_BITS = dqkr_pkg::PLAYER_ID_BITS_DEF,
    localparam int ADDR_W        = $clog2(2 * QUEUE_DEPTH),
    localparam int ENTRY_W       = PLAYER_ID_BITS + dqkr_pkg::TICK_W
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           mode,
    input  logic                 team,
    input  logic [5:0]           player_id,
    input  logic [31:0]          ready_tick,
    input  logic [3:0]           slot_index,
    input  dqkr_pkg::dp_cmd_t    cmd,
    output dqkr_pkg::dp_status_t status,
    output logic                 ram_wr_en,
    output logic [ADDR_W-1:0]    ram_wr_addr,
    output logic [ENTRY_W-1:0]   ram_wr_data,
    output logic                 ram_rd_en,
    output logic [ADDR_W-1:0]    ram_rd_addr,
    input  logic [ENTRY_W-1:0]   ram_rd_data,
    output logic                 ok,
    output logic                 hit_team,
    output logic [3:0]           hit_position,
    output logic [5:0]           entry_player,
    output logic [31:0]          entry_ready_tick,
    output logic [4:0]           count_red,
    output logic [4:0]           count_blue
);

    import dqkr_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int POS_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CMP_W = CNT_W + 4;

    function automatic logic [ADDR_W-1:0] addr_of(input logic t, input logic [CNT_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        base = t ? ADDR_W'(QUEUE_DEPTH) : '0;
        return base + ADDR_W'(idx);
    endfunction

    // request
    mode_t                     mode_reg;
    logic                      team_reg;
    logic [PLAYER_ID_BITS-1:0] pid_reg;
    logic [TICK_W-1:0]         tick_reg;
    logic [3:0]                slot_reg;

    // control state
    logic [CNT_W-1:0] cnt_red_reg, cnt_red_next;
    logic [CNT_W-1:0] cnt_blue_reg, cnt_blue_next;
    logic             srch_team_reg, srch_team_next;
    logic [CNT_W-1:0] srch_idx_reg, srch_idx_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             rd_team_reg, rd_team_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             found_reg, found_next;
    logic             found_team_reg, found_team_next;
    logic [POS_W-1:0] found_pos_reg, found_pos_next;
    logic [CNT_W-1:0] shift_idx_reg, shift_idx_next;

    // staged result
    logic                      res_ok_reg;
    logic                      res_team_reg;
    logic [POS_W-1:0]          res_pos_reg;
    logic [PLAYER_ID_BITS-1:0] res_player_reg;
    logic [TICK_W-1:0]         res_tick_reg;

    // output holding registers
    logic        ok_reg;
    logic        hit_team_reg;
    logic [3:0]  hit_pos_reg;
    logic [5:0]  entry_player_reg;
    logic [31:0] entry_tick_reg;
    logic [4:0]  count_red_reg;
    logic [4:0]  count_blue_reg;

    logic [PLAYER_ID_BITS-1:0] rd_pid;
    logic [TICK_W-1:0]         rd_tick;
    logic [CNT_W-1:0]          srch_cnt, team_cnt, found_cnt;
    logic                      srch_in_range, scan_exhausted, hit_now;
    logic                      enq_ok, read_ok, shift_in_range;
    logic [CNT_W:0]            cnt_sum;

    assign rd_pid  = ram_rd_data[ENTRY_W-1:TICK_W];
    assign rd_tick = ram_rd_data[TICK_W-1:0];

    assign srch_cnt  = srch_team_reg ? cnt_blue_reg : cnt_red_reg;
    assign team_cnt  = team_reg ? cnt_blue_reg : cnt_red_reg;
    assign found_cnt = found_team_reg ? cnt_blue_reg : cnt_red_reg;

    assign srch_in_range  = srch_idx_reg < srch_cnt;
    assign scan_exhausted = srch_team_reg && !srch_in_range;
    assign hit_now        = rd_pend_reg && !found_reg && (rd_pid == pid_reg);
    assign enq_ok         = !found_reg && (team_cnt != CNT_W'(QUEUE_DEPTH));
    assign read_ok        = CMP_W'(slot_reg) < CMP_W'(team_cnt);
    // counts are already decremented while shifting
    assign shift_in_range = shift_idx_reg <= found_cnt;
    assign cnt_sum        = (CNT_W + 1)'(cnt_red_reg) + (CNT_W + 1)'(cnt_blue_reg);

    assign status.mode       = mode_reg;
    assign status.found      = found_reg;
    assign status.scan_done  = found_reg || (scan_exhausted && !rd_pend_reg);
    assign status.shift_done = !shift_in_range && !rd_pend_reg;

    // memory port control
    always_comb
    begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = '0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = '0;
        if (cmd.scan_step && !found_reg && !hit_now && srch_in_range)
        begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = addr_of(srch_team_reg, srch_idx_reg);
        end
        if (cmd.read_issue)
        begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = (team_reg ? ADDR_W'(QUEUE_DEPTH) : '0) + ADDR_W'(slot_reg);
        end
        if (cmd.decide && mode_reg == MODE_ENQUEUE && enq_ok)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = addr_of(team_reg, team_cnt);
            ram_wr_data = {pid_reg, tick_reg};
        end
        if (cmd.shift_step)
        begin
            if (shift_in_range)
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = addr_of(found_team_reg, shift_idx_reg);
            end
            // entry behind moves up one slot
            if (rd_pend_reg)
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = addr_of(found_team_reg, rd_idx_reg - 1'b1);
                ram_wr_data = ram_rd_data;
            end
        end
    end

    // control next state
    always_comb
    begin
        cnt_red_next    = cnt_red_reg;
        cnt_blue_next   = cnt_blue_reg;
        srch_team_next  = srch_team_reg;
        srch_idx_next   = srch_idx_reg;
        rd_pend_next    = 1'b0;
        rd_team_next    = rd_team_reg;
        rd_idx_next     = rd_idx_reg;
        found_next      = found_reg;
        found_team_next = found_team_reg;
        found_pos_next  = found_pos_reg;
        shift_idx_next  = shift_idx_reg;

        if (cmd.load)
        begin
            srch_team_next  = 1'b0;
            srch_idx_next   = '0;
            found_next      = 1'b0;
            found_team_next = 1'b0;
            found_pos_next  = '0;
        end

        if (cmd.scan_step)
        begin
            if (hit_now)
            begin
                found_next      = 1'b1;
                found_team_next = rd_team_reg;
                found_pos_next  = POS_W'(rd_idx_reg);
            end
            else if (!found_reg)
            begin
                if (srch_in_range)
                begin
                    rd_pend_next  = 1'b1;
                    rd_team_next  = srch_team_reg;
                    rd_idx_next   = srch_idx_reg;
                    srch_idx_next = srch_idx_reg + 1'b1;
                end
                else if (!srch_team_reg)
                begin
                    // red exhausted, go on with blue
                    srch_team_next = 1'b1;
                    srch_idx_next  = '0;
                end
            end
        end

        if (cmd.decide)
        begin
            case (mode_reg)
                MODE_ENQUEUE:
                begin
                    if (enq_ok)
                    begin
                        if (team_reg)
                        begin
                            cnt_blue_next = cnt_blue_reg + 1'b1;
                        end
                        else
                        begin
                            cnt_red_next = cnt_red_reg + 1'b1;
                        end
                    end
                end
                MODE_REMOVE:
                begin
                    if (found_reg)
                    begin
                        if (found_team_reg)
                        begin
                            cnt_blue_next = cnt_blue_reg - 1'b1;
                        end
                        else
                        begin
                            cnt_red_next = cnt_red_reg - 1'b1;
                        end
                        shift_idx_next = CNT_W'(found_pos_reg) + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.shift_step && shift_in_range)
        begin
            rd_pend_next   = 1'b1;
            rd_idx_next    = shift_idx_reg;
            shift_idx_next = shift_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_red_reg    <= '0;
            cnt_blue_reg   <= '0;
            srch_team_reg  <= 1'b0;
            srch_idx_reg   <= '0;
            rd_pend_reg    <= 1'b0;
            rd_team_reg    <= 1'b0;
            rd_idx_reg     <= '0;
            found_reg      <= 1'b0;
            found_team_reg <= 1'b0;
            found_pos_reg  <= '0;
            shift_idx_reg  <= '0;
        end
        else
        begin
            cnt_red_reg    <= cnt_red_next;
            cnt_blue_reg   <= cnt_blue_next;
            srch_team_reg  <= srch_team_next;
            srch_idx_reg   <= srch_idx_next;
            rd_pend_reg    <= rd_pend_next;
            rd_team_reg    <= rd_team_next;
            rd_idx_reg     <= rd_idx_next;
            found_reg      <= found_next;
            found_team_reg <= found_team_next;
            found_pos_reg  <= found_pos_next;
            shift_idx_reg  <= shift_idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode_t'(mode);
            team_reg <= team;
            pid_reg  <= PLAYER_ID_BITS'(player_id);
            tick_reg <= ready_tick;
            slot_reg <= slot_index;
        end

        if (cmd.decide)
        begin
            res_player_reg <= '0;
            res_tick_reg   <= '0;
            if (mode_reg == MODE_ENQUEUE)
            begin
                res_ok_reg   <= enq_ok;
                res_team_reg <= enq_ok ? team_reg : 1'b0;
                res_pos_reg  <= enq_ok ? POS_W'(team_cnt) : '0;
            end
            else
            begin
                res_ok_reg   <= found_reg;
                res_team_reg <= found_team_reg;
                res_pos_reg  <= found_pos_reg;
            end
        end

        if (cmd.read_issue)
        begin
            res_ok_reg     <= read_ok;
            res_team_reg   <= team_reg;
            res_pos_reg    <= read_ok ? POS_W'(slot_reg) : '0;
            res_player_reg <= '0;
            res_tick_reg   <= '0;
        end

        if (cmd.read_capture && res_ok_reg)
        begin
            res_player_reg <= rd_pid;
            res_tick_reg   <= rd_tick;
        end

        if (cmd.publish)
        begin
            ok_reg           <= res_ok_reg;
            hit_team_reg     <= res_team_reg;
            hit_pos_reg      <= 4'(res_pos_reg);
            entry_player_reg <= 6'(res_player_reg);
            entry_tick_reg   <= res_tick_reg;
            count_red_reg    <= 5'(cnt_red_reg);
            count_blue_reg   <= 5'(cnt_blue_reg);
        end
    end

    assign ok               = ok_reg;
    assign hit_team         = hit_team_reg;
    assign hit_position     = hit_pos_reg;
    assign entry_player     = entry_player_reg;
    assign entry_ready_tick = entry_tick_reg;
    assign count_red        = count_red_reg;
    assign count_blue       = count_blue_reg;

    `DQKR_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, cnt_red_reg <= CNT_W'(QUEUE_DEPTH) && cnt_blue_reg <= CNT_W'(QUEUE_DEPTH))
    `DQKR_ASSERT_NEXT(a_remove_shrinks, clk, rst_n, cmd.decide && mode_reg == MODE_REMOVE && found_reg, (cnt_sum + 1'b1) == $past(cnt_sum))

endmodule

// ===== rtl/core/dual_queue_keyed_remove.sv =====
// ----------------------------------------------------------------------------
// dual_queue_keyed_remove
// two ordered team queues sharing one player id space, with keyed remove
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_ready   mode team player_id ready_tick slot_index
//  out      source     out_valid / out_ready ok hit_team hit_position entry_player
//                                            entry_ready_tick count_red count_blue
//
//  one item at a time; a read issues its ram read, captures the entry, then publishes
//  enqueue and lookup scan red, then blue, serially through the single ram read port;
//  a hit ends the scan early
//  remove then moves each entry behind the hit up one slot
//  the result sits in an output register, so the next item is taken while it waits
//  rst_n clears the counts and control; the entry ram needs no clearing pass
//
module dual_queue_keyed_remove #(
    parameter int QUEUE_DEPTH    = dqkr_pkg::QUEUE_DEPTH_DEF,
    parameter int PLAYER_ID_BITS = dqkr_pkg::PLAYER_ID_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic        team,
    input  logic [5:0]  player_id,
    input  logic [31:0] ready_tick,
    input  logic [3:0]  slot_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        ok,
    output logic        hit_team,
    output logic [3:0]  hit_position,
    output logic [5:0]  entry_player,
    output logic [31:0] entry_ready_tick,
    output logic [4:0]  count_red,
    output logic [4:0]  count_blue
);

    import dqkr_pkg::*;

    // both queues live in one ram: red in the low half, blue in the high half
    localparam int RAM_DEPTH = 2 * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);
    // entry word is {player id, ready tick}
    localparam int ENTRY_W   = PLAYER_ID_BITS + TICK_W;

    dp_cmd_t    cmd;
    dp_status_t status;

    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;

    // sequencer: load, scan, decide, shift or read, publish
    dqkr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // counts, search and shift pointers, result and output registers
    dqkr_datapath #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .PLAYER_ID_BITS (PLAYER_ID_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .mode             (mode),
        .team             (team),
        .player_id        (player_id),
        .ready_tick       (ready_tick),
        .slot_index       (slot_index),
        .cmd              (cmd),
        .status           (status),
        .ram_wr_en        (ram_wr_en),
        .ram_wr_addr      (ram_wr_addr),
        .ram_wr_data      (ram_wr_data),
        .ram_rd_en        (ram_rd_en),
        .ram_rd_addr      (ram_rd_addr),
        .ram_rd_data      (ram_rd_data),
        .ok               (ok),
        .hit_team         (hit_team),
        .hit_position     (hit_position),
        .entry_player     (entry_player),
        .entry_ready_tick (entry_ready_tick),
        .count_red        (count_red),
        .count_blue       (count_blue)
    );

    // entry storage; data read from slots that hold no queued entry is never used
    dqkr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule
